// File: hw/rtl/fpsm_pkg.sv
// Shared constants for the Fibonacci product sum block.
package fpsm_pkg;
   // Operand selections for the shared multiplier.
   localparam logic [2:0] OpDouble = 3'd0;  // F(k) * (2F(k+1) - F(k))
   localparam logic [2:0] OpSqA    = 3'd1;  // F(k) squared
   localparam logic [2:0] OpSqB    = 3'd2;  // F(k+1) squared
   localparam logic [2:0] OpProdAb = 3'd3;  // F(a) * F(b)
   localparam logic [2:0] OpProdCd = 3'd4;  // F(c) * F(d)
endpackage

// File: hw/rtl/fpsm_modmul.sv
// Bit-serial modular multiplier: (x * y) mod m, one multiplier bit per cycle.
module fpsm_modmul #(
   parameter int unsigned MOD_WIDTH = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MOD_WIDTH-1:0] x,
   input  logic [MOD_WIDTH-1:0] y,
   input  logic [MOD_WIDTH-1:0] m,
   output logic                 done,
   output logic [MOD_WIDTH-1:0] p
);
   localparam int unsigned CntWidth = $clog2(MOD_WIDTH + 1);

   logic [MOD_WIDTH-1:0] acc_ff, acc_in, xs_ff, xs_in, yr_ff, yr_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [MOD_WIDTH:0]   dbl, dbl_r, add;
   logic [MOD_WIDTH-1:0] dbl_m, add_m;

   // Horner form from the top bit of x: acc = 2*acc (+ y), each kept below m.
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_m = (dbl >= {1'b0, m}) ? MOD_WIDTH'(dbl - {1'b0, m}) : dbl[MOD_WIDTH-1:0];
      dbl_r = {1'b0, dbl_m};
      add   = dbl_r + {1'b0, yr_ff};
      add_m = (add >= {1'b0, m}) ? MOD_WIDTH'(add - {1'b0, m}) : add[MOD_WIDTH-1:0];
      acc_in  = acc_ff;
      xs_in   = xs_ff;
      yr_in   = yr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         xs_in   = x;
         yr_in   = (y >= m) ? MOD_WIDTH'(y - m) : y;
         cnt_in  = CntWidth'(MOD_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = xs_ff[MOD_WIDTH-1] ? add_m : dbl_m;
         xs_in  = {xs_ff[MOD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      xs_ff  <= xs_in;
      yr_ff  <= yr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;
endmodule

// File: hw/rtl/fibonacci_product_sum_mod.sv
// Top level of the Fibonacci product sum modulo m block.
// Computes (F(a)F(b) + F(c)F(d)) mod m. One request is worked at a time; each
// index is scanned one exponent bit per step, from the top bit down, with a
// fast-doubling step built from three modular products in one shared bit-serial
// multiplier. A request runs INDEX_WIDTH such steps for each of the four
// indices, then two more products. A zero or unit modulus gives a zero residue
// and skips the products. The next request is taken as soon as the block is
// idle; a finished residue waits in a staging register until the output
// register is free, so one result may be held at the output while the next
// request is worked.
module fibonacci_product_sum_mod #(
   parameter int unsigned MOD_WIDTH   = 31,
   parameter int unsigned INDEX_WIDTH = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   // index_a, index_b, index_c, index_d, modulus from bit 0 up, zero filled
   input  logic [((4*INDEX_WIDTH+MOD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // residue
   output logic [((MOD_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   localparam int unsigned RspBits = ((MOD_WIDTH+7)/8)*8;
   localparam int unsigned BitCnt  = $clog2(INDEX_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_WAIT, ST_NEXT, ST_FIN, ST_FWAIT, ST_OUT
   } state_type;

   state_type state_ff;
   logic [INDEX_WIDTH-1:0] idx_ff [4];
   logic [MOD_WIDTH-1:0]   m_ff, fa_ff, fb_ff, pf_ff, p0_ff;
   logic [MOD_WIDTH-1:0]   t_ff [4];
   logic [MOD_WIDTH-1:0]   fib_ff [4];
   logic [1:0]             which_ff;
   logic [BitCnt-1:0]      bit_ff;
   logic [2:0]             op_ff;
   logic                   rv_ff;
   logic [MOD_WIDTH-1:0]   res_ff;

   logic                 mstart, mdone;
   logic [MOD_WIDTH-1:0] mx, my, mp;

   fpsm_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
      .clock(clock), .reset(reset), .start(mstart),
      .x(mx), .y(my), .m(m_ff), .done(mdone), .p(mp)
   );

   // Modular add and subtract of reduced values.
   function automatic logic [MOD_WIDTH-1:0] madd(input logic [MOD_WIDTH-1:0] u, v, mm);
      logic [MOD_WIDTH:0] s;
      s = {1'b0, u} + {1'b0, v};
      return (s >= {1'b0, mm}) ? MOD_WIDTH'(s - {1'b0, mm}) : s[MOD_WIDTH-1:0];
   endfunction
   function automatic logic [MOD_WIDTH-1:0] msub(input logic [MOD_WIDTH-1:0] u, v, mm);
      return (u >= v) ? MOD_WIDTH'(u - v) : MOD_WIDTH'({1'b0, u} + {1'b0, mm} - {1'b0, v});
   endfunction

   logic [MOD_WIDTH-1:0] two_b_a;
   assign two_b_a = msub(madd(fb_ff, fb_ff, m_ff), fa_ff, m_ff);

   // Doubling: F(2k)=F(k)(2F(k+1)-F(k)), F(2k+1)=F(k)^2+F(k+1)^2.
   // Products: t0=a*(2b-a), t1=a*a, t2=b*b.
   always_comb begin
      unique case (op_ff)
         fpsm_pkg::OpDouble: begin mx = fa_ff; my = two_b_a; end
         fpsm_pkg::OpSqA:    begin mx = fa_ff; my = fa_ff; end
         fpsm_pkg::OpSqB:    begin mx = fb_ff; my = fb_ff; end
         fpsm_pkg::OpProdAb: begin mx = fib_ff[0]; my = fib_ff[1]; end
         fpsm_pkg::OpProdCd: begin mx = fib_ff[2]; my = fib_ff[3]; end
         default:            begin mx = fa_ff; my = fb_ff; end
      endcase
   end

   assign mstart     = (state_ff == ST_MUL) || (state_ff == ST_FIN);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = RspBits'(res_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  for (int i = 0; i < 4; i++) begin
                     idx_ff[i] <= req_tdata[i*INDEX_WIDTH +: INDEX_WIDTH];
                  end
                  m_ff     <= req_tdata[4*INDEX_WIDTH +: MOD_WIDTH];
                  which_ff <= 2'd0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               // Trivial moduli give zero; otherwise start from F(0)=0, F(1)=1.
               if (m_ff <= MOD_WIDTH'(1)) begin
                  pf_ff    <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  fa_ff    <= '0;
                  fb_ff    <= MOD_WIDTH'(1);
                  bit_ff   <= BitCnt'(INDEX_WIDTH);
                  op_ff    <= fpsm_pkg::OpDouble;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (mdone) begin
                  t_ff[op_ff[1:0]] <= mp;
                  if (op_ff == fpsm_pkg::OpSqB) begin
                     state_ff <= ST_NEXT;
                  end else begin
                     op_ff    <= op_ff + 3'd1;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_NEXT: begin
               // t0 holds F(2k) and t1+t2 gives F(2k+1); advance by the current index bit.
               if (idx_ff[which_ff][BitCnt'(bit_ff - 1'b1)]) begin
                  fa_ff <= madd(t_ff[1], t_ff[2], m_ff);
                  fb_ff <= madd(t_ff[0], madd(t_ff[1], t_ff[2], m_ff), m_ff);
               end else begin
                  fa_ff <= t_ff[0];
                  fb_ff <= madd(t_ff[1], t_ff[2], m_ff);
               end
               op_ff <= fpsm_pkg::OpDouble;
               if (bit_ff == BitCnt'(1)) begin
                  fib_ff[which_ff] <= idx_ff[which_ff][0]
                     ? madd(t_ff[1], t_ff[2], m_ff) : t_ff[0];
                  if (which_ff == 2'd3) begin
                     op_ff    <= fpsm_pkg::OpProdAb;
                     state_ff <= ST_FIN;
                  end else begin
                     which_ff <= which_ff + 2'd1;
                     state_ff <= ST_LOAD;
                  end
               end else begin
                  bit_ff   <= bit_ff - 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_FIN: state_ff <= ST_FWAIT;
            ST_FWAIT: begin
               if (mdone) begin
                  if (op_ff == fpsm_pkg::OpProdAb) begin
                     p0_ff    <= mp;
                     op_ff    <= fpsm_pkg::OpProdCd;
                     state_ff <= ST_FIN;
                  end else begin
                     pf_ff    <= madd(p0_ff, mp, m_ff);
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_OUT: begin
               // Hold the staged residue until the output register is free.
               if (!rv_ff) begin
                  res_ff   <= pf_ff;
                  rv_ff    <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
